// File: hdl/nss_pkg.sv
// ----------------------------------------------------------------------------
// nss_pkg
// Shared types and constants of the nearest spectrum search unit.
// ----------------------------------------------------------------------------
package nss_pkg;

    localparam int BANDS_DEFAULT = 64;
    localparam int BAND_W        = 16;
    localparam int COL_W         = 16;
    localparam int SUM_W         = 38;
    localparam int ROOT_W        = 19;
    localparam int VALUE_W       = 19;
    localparam int KIND_W        = 2;
    localparam int SQ_W          = 2 * BAND_W;

    localparam logic [COL_W-1:0] COLUMNS_RESET = 16'd512;

    typedef enum logic [KIND_W-1:0] {
        KIND_BANDS    = 2'd0,
        KIND_ROW      = 2'd1,
        KIND_COLUMN   = 2'd2,
        KIND_DISTANCE = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_PIX,
        S_ROOT,
        S_EMIT_RD,
        S_EMIT_BAND,
        S_ROW,
        S_COL,
        S_DIST
    } state_t;

    typedef struct packed {
        logic  accept;
        logic  square;
        logic  accumulate;
        logic  pixel_done;
        logic  root_start;
        logic  clear_idx;
        logic  next_idx;
        logic  load_out;
        kind_t out_kind;
        logic  restart;
    } ctrl_cmd_t;

    typedef struct packed {
        logic item_eoi;
        logic last_pair;
        logic last_idx;
        logic out_free;
        logic root_done;
    } dp_status_t;

endpackage

// File: hdl/nss_if.sv
// ----------------------------------------------------------------------------
// nss_if
// Request channels of the nearest spectrum search unit.
// ----------------------------------------------------------------------------
interface nss_in_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [nss_pkg::BAND_W-1:0]  low_band;
    logic [nss_pkg::BAND_W-1:0]  high_band;
    logic                        end_of_image;

    modport source (output valid, mode, low_band, high_band, end_of_image, input ready);
    modport sink (input valid, mode, low_band, high_band, end_of_image, output ready);
endinterface

interface nss_out_if;
    logic                         valid;
    logic                         ready;
    nss_pkg::kind_t               kind;
    logic [nss_pkg::BAND_W-1:0]   out_low_band;
    logic [nss_pkg::BAND_W-1:0]   out_high_band;
    logic [nss_pkg::VALUE_W-1:0]  value;
    logic                         last;

    modport source (output valid, kind, out_low_band, out_high_band, value, last,
                    input ready);
    modport sink (input valid, kind, out_low_band, out_high_band, value, last,
                  output ready);
endinterface

interface nss_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [nss_pkg::COL_W-1:0]  image_columns;

    modport source (output valid, image_columns, input ready);
    modport sink (input valid, image_columns, output ready);
endinterface

// File: hdl/nss_ram.sv
// ----------------------------------------------------------------------------
// nss_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module nss_ram #(
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [0:(1 << ADDR_W)-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/nss_isqrt.sv
// ----------------------------------------------------------------------------
// nss_isqrt
// Floor integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module nss_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [nss_pkg::SUM_W-1:0]   radicand,
    output logic                        done,
    output logic [nss_pkg::ROOT_W-1:0]  root
);

    localparam int STEPS = nss_pkg::ROOT_W;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam int REM_W = nss_pkg::ROOT_W + 3;

    logic [CNT_W-1:0]            cnt_reg;
    logic                        done_reg;
    logic [nss_pkg::SUM_W-1:0]   val_reg;
    logic [REM_W-1:0]            rem_reg;
    logic [nss_pkg::ROOT_W-1:0]  root_reg;
    logic [REM_W-1:0]            rem_shift;
    logic [REM_W-1:0]            trial;
    logic [REM_W-1:0]            rem_next;
    logic [nss_pkg::ROOT_W-1:0]  root_next;

    always_comb
    begin
        rem_shift = {rem_reg[REM_W-3:0], val_reg[nss_pkg::SUM_W-1 -: 2]};
        trial     = REM_W'({root_reg, 2'b01});
        if (rem_shift >= trial)
        begin
            rem_next  = rem_shift - trial;
            root_next = {root_reg[nss_pkg::ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_shift;
            root_next = {root_reg[nss_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(STEPS);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            val_reg  <= {val_reg[nss_pkg::SUM_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: hdl/nss_datapath.sv
// ----------------------------------------------------------------------------
// nss_datapath
// Reference and pixel stores, distance accumulation, best tracking, results.
// ----------------------------------------------------------------------------
module nss_datapath #(
    parameter int BANDS = nss_pkg::BANDS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_mode,
    input  logic [nss_pkg::BAND_W-1:0]  in_low,
    input  logic [nss_pkg::BAND_W-1:0]  in_high,
    input  logic                        in_eoi,
    input  nss_pkg::ctrl_cmd_t          cmd,
    output nss_pkg::dp_status_t         status,
    nss_cfg_if.sink                     cfg,
    nss_out_if.source                   result
);

    localparam int PAIRS  = (BANDS + 1) / 2;
    localparam int PAIR_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;
    localparam int WORD_W = 2 * nss_pkg::BAND_W;
    localparam int BW     = nss_pkg::BAND_W;
    localparam int SW     = nss_pkg::SUM_W;
    localparam int CW     = nss_pkg::COL_W;
    localparam logic [PAIR_W-1:0] LAST_PAIR = PAIR_W'(PAIRS - 1);

    logic [CW-1:0]              cols_reg;
    logic [PAIR_W-1:0]          ref_pos_reg;
    logic [PAIR_W-1:0]          band_pos_reg;
    logic [PAIR_W-1:0]          idx_reg;
    logic                       active_reg;
    logic                       eoi_reg;
    logic [BW-1:0]              lo_reg;
    logic [BW-1:0]              hi_reg;
    logic [nss_pkg::SQ_W-1:0]   sq_lo_reg;
    logic [nss_pkg::SQ_W-1:0]   sq_hi_reg;
    logic [SW-1:0]              running_sum_reg;
    logic [SW-1:0]              best_sum_reg;
    logic [CW-1:0]              best_row_reg;
    logic [CW-1:0]              best_col_reg;
    logic [CW-1:0]              cur_row_reg;
    logic [CW-1:0]              cur_col_reg;
    logic                       out_valid_reg;
    nss_pkg::kind_t             out_kind_reg;
    logic [BW-1:0]              out_lo_reg;
    logic [BW-1:0]              out_hi_reg;
    logic [nss_pkg::VALUE_W-1:0] out_value_reg;
    logic                       out_last_reg;

    logic [WORD_W-1:0]          ref_word;
    logic [WORD_W-1:0]          pix_word;
    logic [BW-1:0]              ref_lo;
    logic [BW-1:0]              ref_hi;
    logic [BW-1:0]              diff_lo;
    logic [BW-1:0]              diff_hi;
    logic [SW-1:0]              sum_base;
    logic [SW:0]                sum_total;
    logic [SW-1:0]              sum_sat;
    logic                       better;
    logic                       col_wrap;
    logic                       root_done;
    logic [nss_pkg::ROOT_W-1:0] root;
    logic                       ref_we;
    logic                       pix_we;

    assign ref_we = cmd.accept && !in_mode;
    assign pix_we = cmd.accept && in_mode;

    nss_ram #(
        .WIDTH  (WORD_W),
        .ADDR_W (PAIR_W)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ref_we),
        .waddr (ref_pos_reg),
        .wdata ({in_high, in_low}),
        .raddr (band_pos_reg),
        .rdata (ref_word)
    );

    nss_ram #(
        .WIDTH  (WORD_W),
        .ADDR_W (PAIR_W + 1)
    ) u_pix_ram (
        .clk   (clk),
        .we    (pix_we),
        .waddr ({active_reg, band_pos_reg}),
        .wdata ({in_high, in_low}),
        .raddr ({~active_reg, idx_reg}),
        .rdata (pix_word)
    );

    nss_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.root_start),
        .radicand (best_sum_reg),
        .done     (root_done),
        .root     (root)
    );

    always_comb
    begin
        ref_lo    = ref_word[BW-1:0];
        ref_hi    = ref_word[WORD_W-1:BW];
        diff_lo   = (ref_lo >= lo_reg) ? ref_lo - lo_reg : lo_reg - ref_lo;
        diff_hi   = (ref_hi >= hi_reg) ? ref_hi - hi_reg : hi_reg - ref_hi;
        sum_base  = (band_pos_reg == '0) ? '0 : running_sum_reg;
        sum_total = {1'b0, sum_base} + (SW + 1)'(sq_lo_reg) + (SW + 1)'(sq_hi_reg);
        sum_sat   = sum_total[SW] ? {SW{1'b1}} : sum_total[SW-1:0];
        better    = running_sum_reg < best_sum_reg;
        col_wrap  = ({1'b0, cur_col_reg} + 1'b1) >= {1'b0, cols_reg};
    end

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= nss_pkg::COLUMNS_RESET;
        end
        else if (cfg.valid)
        begin
            cols_reg <= cfg.image_columns;
        end
    end

    // run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_pos_reg     <= '0;
            band_pos_reg    <= '0;
            active_reg      <= 1'b0;
            running_sum_reg <= '0;
            best_sum_reg    <= '1;
            best_row_reg    <= '0;
            best_col_reg    <= '0;
            cur_row_reg     <= '0;
            cur_col_reg     <= '0;
            eoi_reg         <= 1'b0;
            idx_reg         <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                eoi_reg <= in_eoi;
            end
            if (ref_we)
            begin
                ref_pos_reg <= (ref_pos_reg == LAST_PAIR) ? '0 : ref_pos_reg + 1'b1;
            end
            if (cmd.accumulate)
            begin
                running_sum_reg <= sum_sat;
                band_pos_reg    <= (band_pos_reg == LAST_PAIR) ? '0 : band_pos_reg + 1'b1;
            end
            if (cmd.pixel_done)
            begin
                if (better)
                begin
                    best_sum_reg <= running_sum_reg;
                    best_row_reg <= cur_row_reg;
                    best_col_reg <= cur_col_reg;
                    active_reg   <= ~active_reg;
                end
                if (col_wrap)
                begin
                    cur_col_reg <= '0;
                    cur_row_reg <= cur_row_reg + 1'b1;
                end
                else
                begin
                    cur_col_reg <= cur_col_reg + 1'b1;
                end
            end
            if (cmd.clear_idx)
            begin
                idx_reg <= '0;
            end
            else if (cmd.next_idx)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.restart)
            begin
                ref_pos_reg     <= '0;
                band_pos_reg    <= '0;
                active_reg      <= 1'b0;
                running_sum_reg <= '0;
                best_sum_reg    <= '1;
                best_row_reg    <= '0;
                best_col_reg    <= '0;
                cur_row_reg     <= '0;
                cur_col_reg     <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            lo_reg <= in_low;
            hi_reg <= in_high;
        end
        if (cmd.square)
        begin
            sq_lo_reg <= diff_lo * diff_lo;
            sq_hi_reg <= diff_hi * diff_hi;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_kind_reg <= cmd.out_kind;
            unique case (cmd.out_kind)
                nss_pkg::KIND_BANDS:
                begin
                    out_lo_reg    <= pix_word[BW-1:0];
                    out_hi_reg    <= pix_word[WORD_W-1:BW];
                    out_value_reg <= '0;
                    out_last_reg  <= 1'b0;
                end
                nss_pkg::KIND_ROW:
                begin
                    out_lo_reg    <= '0;
                    out_hi_reg    <= '0;
                    out_value_reg <= nss_pkg::VALUE_W'(best_row_reg);
                    out_last_reg  <= 1'b0;
                end
                nss_pkg::KIND_COLUMN:
                begin
                    out_lo_reg    <= '0;
                    out_hi_reg    <= '0;
                    out_value_reg <= nss_pkg::VALUE_W'(best_col_reg);
                    out_last_reg  <= 1'b0;
                end
                nss_pkg::KIND_DISTANCE:
                begin
                    out_lo_reg    <= '0;
                    out_hi_reg    <= '0;
                    out_value_reg <= nss_pkg::VALUE_W'(root);
                    out_last_reg  <= 1'b1;
                end
                default:
                begin
                    out_lo_reg    <= '0;
                    out_hi_reg    <= '0;
                    out_value_reg <= '0;
                    out_last_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.kind          = out_kind_reg;
    assign result.out_low_band  = out_lo_reg;
    assign result.out_high_band = out_hi_reg;
    assign result.value         = out_value_reg;
    assign result.last          = out_last_reg;

    always_comb
    begin
        status.item_eoi  = eoi_reg;
        status.last_pair = band_pos_reg == LAST_PAIR;
        status.last_idx  = idx_reg == LAST_PAIR;
        status.out_free  = !out_valid_reg || result.ready;
        status.root_done = root_done;
    end

`ifndef SYNTHESIS
    a_band_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        band_pos_reg <= LAST_PAIR)
        else $error("band position past last pair");

    a_ref_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        ref_pos_reg <= LAST_PAIR)
        else $error("reference position past last pair");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || result.ready))
        else $error("result overwritten before taken");

    a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pixel_done |=> best_sum_reg <= $past(best_sum_reg))
        else $error("best sum grew on pixel update");
`endif

endmodule

// File: hdl/nss_ctrl.sv
// ----------------------------------------------------------------------------
// nss_ctrl
// Sequencer for word processing, pixel decisions and result emission.
// ----------------------------------------------------------------------------
module nss_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_mode,
    output logic                 in_ready,
    input  nss_pkg::dp_status_t  status,
    output nss_pkg::ctrl_cmd_t   cmd
);

    nss_pkg::state_t state_reg;
    nss_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nss_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nss_pkg::S_IDLE:
            begin
                if (in_valid && in_mode)
                begin
                    state_next = nss_pkg::S_MUL;
                end
            end
            nss_pkg::S_MUL:
            begin
                state_next = nss_pkg::S_ACC;
            end
            nss_pkg::S_ACC:
            begin
                priority if (status.last_pair)
                begin
                    state_next = nss_pkg::S_PIX;
                end
                else if (status.item_eoi)
                begin
                    state_next = nss_pkg::S_ROOT;
                end
                else
                begin
                    state_next = nss_pkg::S_IDLE;
                end
            end
            nss_pkg::S_PIX:
            begin
                state_next = status.item_eoi ? nss_pkg::S_ROOT : nss_pkg::S_IDLE;
            end
            nss_pkg::S_ROOT:
            begin
                state_next = nss_pkg::S_EMIT_RD;
            end
            nss_pkg::S_EMIT_RD:
            begin
                state_next = nss_pkg::S_EMIT_BAND;
            end
            nss_pkg::S_EMIT_BAND:
            begin
                if (status.out_free)
                begin
                    state_next = status.last_idx ? nss_pkg::S_ROW : nss_pkg::S_EMIT_RD;
                end
            end
            nss_pkg::S_ROW:
            begin
                if (status.out_free)
                begin
                    state_next = nss_pkg::S_COL;
                end
            end
            nss_pkg::S_COL:
            begin
                if (status.out_free)
                begin
                    state_next = nss_pkg::S_DIST;
                end
            end
            nss_pkg::S_DIST:
            begin
                if (status.out_free && status.root_done)
                begin
                    state_next = nss_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = nss_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            nss_pkg::S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            nss_pkg::S_MUL:
            begin
                cmd.square = 1'b1;
            end
            nss_pkg::S_ACC:
            begin
                cmd.accumulate = 1'b1;
            end
            nss_pkg::S_PIX:
            begin
                cmd.pixel_done = 1'b1;
            end
            nss_pkg::S_ROOT:
            begin
                cmd.root_start = 1'b1;
                cmd.clear_idx  = 1'b1;
            end
            nss_pkg::S_EMIT_RD:
            begin
                cmd.out_kind = nss_pkg::KIND_BANDS;
            end
            nss_pkg::S_EMIT_BAND:
            begin
                cmd.out_kind = nss_pkg::KIND_BANDS;
                cmd.load_out = status.out_free;
                cmd.next_idx = status.out_free;
            end
            nss_pkg::S_ROW:
            begin
                cmd.out_kind = nss_pkg::KIND_ROW;
                cmd.load_out = status.out_free;
            end
            nss_pkg::S_COL:
            begin
                cmd.out_kind = nss_pkg::KIND_COLUMN;
                cmd.load_out = status.out_free;
            end
            nss_pkg::S_DIST:
            begin
                cmd.out_kind = nss_pkg::KIND_DISTANCE;
                cmd.load_out = status.out_free && status.root_done;
                cmd.restart  = status.out_free && status.root_done;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_pix_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == nss_pkg::S_PIX |-> $past(state_reg) == nss_pkg::S_ACC)
        else $error("pixel decision without accumulation");

    a_mul_after_image_word: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == nss_pkg::S_MUL |-> $past(in_valid && in_ready && in_mode))
        else $error("square step without image word");

    a_dist_root_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && cmd.out_kind == nss_pkg::KIND_DISTANCE) |-> status.root_done)
        else $error("distance loaded before root finished");
`endif

endmodule

// File: hdl/nearest_spectrum_search_unit.sv
// ----------------------------------------------------------------------------
// nearest_spectrum_search_unit
// Finds the image pixel closest to a reference spectrum (sum of squares).
//
// Channel   Direction  Payload
// pixel     sink       mode, low_band, high_band, end_of_image
// result    source     kind, out_low_band, out_high_band, value, last
// cfg       sink       image_columns
//
// Reference word: taken in the idle state alone. Image word: read, square and
// accumulate steps, plus a best-pixel compare step on the last pair of a pixel.
// End of image: each band pair result takes a read state and an emit state through
// the pixel RAM read port, then row and column; distance waits for the bit-serial root unit.
// Result ready low stalls emission; no word is taken until the run's last result
// is loaded. Asynchronous active-low reset, no memory clearing pass.
// ----------------------------------------------------------------------------
module nearest_spectrum_search_unit #(
    parameter int BANDS = nss_pkg::BANDS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    nss_in_if.sink      pixel,
    nss_out_if.source   result,
    nss_cfg_if.sink     cfg
);

    nss_pkg::ctrl_cmd_t  cmd;
    nss_pkg::dp_status_t status;
    logic                in_ready;

    assign pixel.ready = in_ready;

    nss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixel.valid),
        .in_mode  (pixel.mode),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    nss_datapath #(
        .BANDS (BANDS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_mode (pixel.mode),
        .in_low  (pixel.low_band),
        .in_high (pixel.high_band),
        .in_eoi  (pixel.end_of_image),
        .cmd     (cmd),
        .status  (status),
        .cfg     (cfg),
        .result  (result)
    );

endmodule

// File: tb/sv/tb_nearest_spectrum_search_unit.sv
// ----------------------------------------------------------------------------
// tb_nearest_spectrum_search_unit
// Self-checking bench for the nearest spectrum search unit. Loads reference
// spectra and streams images of random pixels under bursty pixel requests
// and a stalling result sink. A scoreboard tracks the closest pixel, its
// position and the integer distance, and compares every result request with
// its own prediction. Column count changes between images and mid-image.
// ----------------------------------------------------------------------------
module tb_nearest_spectrum_search_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BANDS       = nss_pkg::BANDS_DEFAULT;
    localparam int BAND_W      = nss_pkg::BAND_W;
    localparam int COL_W       = nss_pkg::COL_W;
    localparam int VALUE_W     = nss_pkg::VALUE_W;
    localparam int ROOT_W      = nss_pkg::ROOT_W;
    localparam int PAIRS       = (BANDS + 1) / 2;
    localparam int ITEMS       = 330;
    localparam int IDLE_WAIT   = 40;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 40;
    localparam longint unsigned SUM_LIMIT = 64'h3F_FFFF_FFFF;

    typedef struct {
        nss_pkg::kind_t      kind;
        logic [BAND_W-1:0]   lo;
        logic [BAND_W-1:0]   hi;
        logic [VALUE_W-1:0]  value;
        logic                last;
    } closest_result_t;

    class spectrum_scoreboard;
        logic [COL_W-1:0]   columns;
        logic [BAND_W-1:0]  ref_band [2*PAIRS];
        logic [BAND_W-1:0]  pix_buf  [4*PAIRS];
        longint unsigned    run_sum;
        longint unsigned    best_sum;
        logic [15:0]        best_row, best_col, cur_row, cur_col;
        int unsigned        pair_pos, ref_pos;
        bit                 half;
        closest_result_t    pending[$];
        int                 errors;

        function new();
            columns = nss_pkg::COLUMNS_RESET;
            errors  = 0;
            foreach (ref_band[i]) ref_band[i] = '0;
            foreach (pix_buf[i]) pix_buf[i] = '0;
            restart();
        endfunction

        function void restart();
            run_sum  = 0;
            best_sum = SUM_LIMIT;
            best_row = '0;
            best_col = '0;
            cur_row  = '0;
            cur_col  = '0;
            pair_pos = 0;
            ref_pos  = 0;
            half     = 1'b0;
        endfunction

        function longint unsigned sq_gap(logic [BAND_W-1:0] a, logic [BAND_W-1:0] b);
            longint unsigned d;
            d = (a >= b) ? a - b : b - a;
            return d * d;
        endfunction

        function logic [ROOT_W-1:0] floor_root(longint unsigned v);
            longint unsigned r, t;
            int b;
            r = 0;
            for (b = ROOT_W - 1; b >= 0; b--)
            begin
                t = r | (64'd1 << b);
                if (t * t <= v)
                    r = t;
            end
            return r[ROOT_W-1:0];
        endfunction

        function void queue_result(nss_pkg::kind_t k, logic [BAND_W-1:0] lo,
                                   logic [BAND_W-1:0] hi, logic [VALUE_W-1:0] v,
                                   logic last);
            closest_result_t r;
            r.kind  = k;
            r.lo    = lo;
            r.hi    = hi;
            r.value = v;
            r.last  = last;
            pending.push_back(r);
        endfunction

        function void note_word(logic mode, logic [BAND_W-1:0] lo, logic [BAND_W-1:0] hi,
                                logic eoi);
            int unsigned base, closest, i;
            longint unsigned total;
            if (mode == 1'b0)
            begin
                ref_band[2*ref_pos]     = lo;
                ref_band[2*ref_pos + 1] = hi;
                ref_pos = (ref_pos + 1 >= PAIRS) ? 0 : ref_pos + 1;
                return;
            end
            if (pair_pos == 0)
                run_sum = 0;
            base = half ? 2 * PAIRS : 0;
            pix_buf[base + 2*pair_pos]     = lo;
            pix_buf[base + 2*pair_pos + 1] = hi;
            total = run_sum + sq_gap(ref_band[2*pair_pos], lo)
                    + sq_gap(ref_band[2*pair_pos + 1], hi);
            run_sum = (total > SUM_LIMIT) ? SUM_LIMIT : total;
            if (pair_pos + 1 >= PAIRS)
            begin
                if (run_sum < best_sum)
                begin
                    best_sum = run_sum;
                    best_row = cur_row;
                    best_col = cur_col;
                    half     = ~half;
                end
                if ({1'b0, cur_col} + 17'd1 >= {1'b0, columns})
                begin
                    cur_col = '0;
                    cur_row = cur_row + 16'd1;
                end
                else
                    cur_col = cur_col + 16'd1;
                pair_pos = 0;
            end
            else
                pair_pos = pair_pos + 1;
            if (!eoi)
                return;
            closest = half ? 0 : 2 * PAIRS;
            for (i = 0; i < PAIRS; i++)
                queue_result(nss_pkg::KIND_BANDS, pix_buf[closest + 2*i],
                             pix_buf[closest + 2*i + 1], '0, 1'b0);
            queue_result(nss_pkg::KIND_ROW, '0, '0, VALUE_W'(best_row), 1'b0);
            queue_result(nss_pkg::KIND_COLUMN, '0, '0, VALUE_W'(best_col), 1'b0);
            queue_result(nss_pkg::KIND_DISTANCE, '0, '0, floor_root(best_sum), 1'b1);
            restart();
        endfunction

        function void compare(string name, logic [VALUE_W-1:0] exp, logic [VALUE_W-1:0] act);
            if (act !== exp)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp, act);
            end
        endfunction

        function void check_result(nss_pkg::kind_t kind, logic [BAND_W-1:0] lo,
                                   logic [BAND_W-1:0] hi, logic [VALUE_W-1:0] v,
                                   logic last);
            closest_result_t e;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unrequested result: expected none, actual kind %0d value %0h",
                             $time, kind, v);
                return;
            end
            e = pending.pop_front();
            compare("kind", e.kind, kind);
            compare("out_low_band", e.lo, lo);
            compare("out_high_band", e.hi, hi);
            compare("value", e.value, v);
            compare("last", e.last, last);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    nss_in_if  pix_if ();
    nss_out_if res_if ();
    nss_cfg_if cfg_if ();

    nearest_spectrum_search_unit #(
        .BANDS (BANDS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pix_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    spectrum_scoreboard sb;
    int cycle_count = 0;
    int words_sent  = 0;
    int burst_left  = 0;
    int rx_style    = 0;
    int rx_left     = 0;
    logic [BAND_W-1:0] prev_lo [PAIRS];
    logic [BAND_W-1:0] prev_hi [PAIRS];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_if.valid && res_if.ready)
                sb.check_result(res_if.kind, res_if.out_low_band, res_if.out_high_band,
                                res_if.value, res_if.last);
            if (pix_if.valid && pix_if.ready)
                sb.note_word(pix_if.mode, pix_if.low_band, pix_if.high_band,
                             pix_if.end_of_image);
        end
    end

    // result sink stall pattern
    always @(negedge clk)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
        begin
            if (rx_left == 0)
            begin
                rx_style = $urandom_range(0, 3);
                rx_left  = $urandom_range(20, 80);
            end
            rx_left--;
            case (rx_style)
                0:       res_if.ready <= 1'b1;
                1:       res_if.ready <= $urandom_range(0, 1);
                2:       res_if.ready <= (rx_left % 4 == 0);
                default: res_if.ready <= ($urandom_range(0, 9) == 0) ? ~res_if.ready
                                                                      : res_if.ready;
            endcase
        end
    end

    function automatic logic [BAND_W-1:0] rand_band();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return BAND_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [COL_W-1:0] pick_columns();
        case ($urandom_range(0, 6))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'd2;
            3:       return 16'd3;
            4:       return 16'hFFFF;
            5:       return COL_W'($urandom_range(4, 9));
            default: return COL_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_word(input logic mode, input logic [BAND_W-1:0] lo,
                             input logic [BAND_W-1:0] hi, input logic eoi);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                @(negedge clk);
                pix_if.valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        pix_if.valid        = 1'b1;
        pix_if.mode         = mode;
        pix_if.low_band     = lo;
        pix_if.high_band    = hi;
        pix_if.end_of_image = eoi;
        @(posedge clk);
        while (!pix_if.ready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic write_columns(input logic [COL_W-1:0] v);
        @(negedge clk);
        pix_if.valid = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
        @(negedge clk);
        cfg_if.valid         = 1'b1;
        cfg_if.image_columns = v;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        sb.columns = v;
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic send_pixel(input int style, input int nwords, input bit eoi_last);
        logic [BAND_W-1:0] lo, hi;
        int p;
        for (p = 0; p < nwords; p++)
        begin
            case (style)
                0:
                begin
                    lo = rand_band();
                    hi = rand_band();
                end
                1:
                begin
                    lo = sb.ref_band[2*p] + BAND_W'($urandom_range(0, 15)) - 16'd8;
                    hi = sb.ref_band[2*p + 1] + BAND_W'($urandom_range(0, 15)) - 16'd8;
                end
                2:
                begin
                    lo = sb.ref_band[2*p];
                    hi = sb.ref_band[2*p + 1];
                end
                3:
                begin
                    lo = prev_lo[p];
                    hi = prev_hi[p];
                end
                default:
                begin
                    lo = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    hi = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                end
            endcase
            prev_lo[p] = lo;
            prev_hi[p] = hi;
            // reference rewrite in the middle of an image
            if ($urandom_range(0, 39) == 0)
                send_word(1'b0, rand_band(), rand_band(), $urandom_range(0, 1));
            send_word(1'b1, lo, hi, eoi_last && (p == nwords - 1));
        end
    endtask

    task automatic random_run();
        int nref, npix, i;
        bit partial_end;
        if ($urandom_range(0, 3) == 0)
            write_columns(pick_columns());
        case ($urandom_range(0, 5))
            0, 1:    nref = PAIRS;
            2:       nref = PAIRS + $urandom_range(1, 8);
            3:       nref = $urandom_range(1, PAIRS - 1);
            default: nref = 0;
        endcase
        for (i = 0; i < nref; i++)
            send_word(1'b0, rand_band(), rand_band(), $urandom_range(0, 1));
        npix = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
        partial_end = (npix == 0) || ($urandom_range(0, 3) == 0);
        for (i = 0; i < npix; i++)
        begin
            if (i > 0 && $urandom_range(0, 4) == 0)
                write_columns(pick_columns());
            send_pixel($urandom_range(0, 4), PAIRS, !partial_end && (i == npix - 1));
        end
        if (partial_end)
            send_pixel($urandom_range(0, 4), $urandom_range(1, PAIRS - 1), 1'b1);
    endtask

    initial
    begin
        int i;
        sb = new();
        rst_n                = 1'b0;
        pix_if.valid         = 1'b0;
        pix_if.mode          = 1'b0;
        pix_if.low_band      = '0;
        pix_if.high_band     = '0;
        pix_if.end_of_image  = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.image_columns = '0;
        foreach (prev_lo[k])
        begin
            prev_lo[k] = '0;
            prev_hi[k] = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset column count; farthest pixel first, then an exact match
        for (i = 0; i < PAIRS; i++)
            send_word(1'b0, 16'h0000, 16'hFFFF, 1'b0);
        for (i = 0; i < PAIRS; i++)
            send_word(1'b1, 16'hFFFF, 16'h0000, 1'b0);
        for (i = 0; i < PAIRS; i++)
            send_word(1'b1, 16'h0000, 16'hFFFF, i == PAIRS - 1);
        write_columns(16'd0);
        // image ending before any pixel completes
        send_word(1'b1, 16'h1234, 16'hABCD, 1'b1);
        write_columns(16'hFFFF);

        while (words_sent < ITEMS)
            random_run();

        @(negedge clk);
        pix_if.valid = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
